// ----- hdl/aet_pkg.sv -----
package aet_pkg;

  localparam int CAP_DEFAULT = 48;

  localparam int POS_W   = 16;
  localparam int RAD_W   = 12;
  localparam int LIFE_W  = 16;
  localparam int KIND_W  = 2;
  localparam int CMD_W   = 2;
  localparam int CNT_W   = 6;

  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 16;

  localparam logic [LIFE_W-1:0] AGE_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [RAD_W-1:0]        radius;
    logic [LIFE_W-1:0]       life;
    logic [LIFE_W-1:0]       age;
    logic [KIND_W-1:0]       kind;
  } entry_t;

  typedef struct packed {
    logic              append;
    logic              shift;
    logic              tick;
    logic              compact;
    logic [LIFE_W-1:0] step;
  } cell_ctl_t;

endpackage

// ----- hdl/aet_cell.sv -----
module aet_cell #(
  parameter int IDX = 0,
  parameter int CW  = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  aet_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]     count,
  input  aet_pkg::entry_t   entry_new,
  input  aet_pkg::entry_t   nbr_entry,
  input  logic              nbr_kill,
  input  logic              prefix_in,
  output aet_pkg::entry_t   entry,
  output logic              kill,
  output logic              prefix_out
);
  import aet_pkg::*;

  logic              live;
  logic [LIFE_W:0]   age_sum;
  logic [LIFE_W-1:0] age_sat;

  assign live       = CW'(IDX) < count;
  assign age_sum    = {1'b0, entry.age} + {1'b0, ctl.step};
  assign age_sat    = age_sum[LIFE_W] ? AGE_MAX : age_sum[LIFE_W-1:0];
  assign prefix_out = prefix_in | kill;

  always_ff @(posedge clk) begin
    if (ctl.append && (CW'(IDX) == count)) begin
      entry <= entry_new;
    end else if (ctl.shift) begin
      entry <= nbr_entry;
    end else if (ctl.tick) begin
      entry.age <= age_sat;
    end else if (ctl.compact && prefix_out) begin
      entry <= nbr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kill <= 1'b0;
    end else if (ctl.tick) begin
      kill <= live && (age_sat >= entry.life);
    end else if (ctl.compact && prefix_out) begin
      kill <= nbr_kill;
    end
  end

endmodule

// ----- hdl/aging_event_table_core.sv -----
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tuser: command; s_tdata: event fields and time step
// m        out  m_tvalid/m_tready  m_tdata: entry count, flags, expired count
//
// Push, clear and the unused command show a result the cycle after they are taken;
// a tick then removes expired entries, the cell chain closing one gap per cycle.
// A new item is taken while the previous result is being taken in the same cycle.
// Reset empties the table at once; entry storage is not cleared.
// A stalled result holds until taken; the input waits while a tick is compacting.
module aging_event_table_core #(
  parameter int TABLE_CAP = aet_pkg::CAP_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // pos_x[15:0], pos_y[31:16], radius[43:32], lifetime[59:44], kind[61:60],
  // time_step[77:62], zero[79:78]
  input  logic [aet_pkg::S_TDATA_W-1:0] s_tdata,
  // command[1:0]
  input  logic [aet_pkg::CMD_W-1:0]     s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // entry_count[5:0], push_rejected[6], oldest_evicted[7], expired_count[13:8],
  // zero[15:14]
  output logic [aet_pkg::M_TDATA_W-1:0] m_tdata
);
  import aet_pkg::*;

  localparam int CW = $clog2(TABLE_CAP + 1);

  typedef enum logic {
    ST_IDLE,
    ST_COMPACT
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [CW-1:0] expired;

  cmd_t      cmd;
  entry_t    entry_new;
  logic [LIFE_W-1:0] step;
  logic      accept;
  logic      reject;
  logic      full;
  logic      any_kill;
  cell_ctl_t ctl;

  entry_t ent    [TABLE_CAP];
  logic   kill   [TABLE_CAP];
  logic   prefix [TABLE_CAP+1];

  assign cmd              = cmd_t'(s_tuser);
  assign entry_new.pos_x  = s_tdata[15:0];
  assign entry_new.pos_y  = s_tdata[31:16];
  assign entry_new.radius = s_tdata[43:32];
  assign entry_new.life   = s_tdata[59:44];
  assign entry_new.age    = '0;
  assign entry_new.kind   = s_tdata[61:60];
  assign step             = s_tdata[77:62];

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign reject   = (entry_new.radius == '0) || (entry_new.life == '0);
  assign full     = count == CW'(TABLE_CAP);
  assign any_kill = prefix[TABLE_CAP];

  assign ctl.append  = accept && (cmd == CMD_PUSH) && !reject && !full;
  assign ctl.shift   = accept && (cmd == CMD_PUSH) && !reject && full;
  assign ctl.tick    = accept && (cmd == CMD_TICK);
  assign ctl.compact = (state == ST_COMPACT) && any_kill;
  assign ctl.step    = step;

  assign prefix[0] = 1'b0;

  for (genvar i = 0; i < TABLE_CAP; i++) begin : g_cell
    entry_t nbr_entry;
    logic   nbr_kill;

    if (i == TABLE_CAP - 1) begin : g_end
      assign nbr_entry = entry_new;
      assign nbr_kill  = 1'b0;
    end else begin : g_mid
      assign nbr_entry = ent[i+1];
      assign nbr_kill  = kill[i+1];
    end

    aet_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .count      (count),
      .entry_new  (entry_new),
      .nbr_entry  (nbr_entry),
      .nbr_kill   (nbr_kill),
      .prefix_in  (prefix[i]),
      .entry      (ent[i]),
      .kill       (kill[i]),
      .prefix_out (prefix[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      expired  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_PUSH: begin
                m_tvalid <= 1'b1;
                if (reject) begin
                  m_tdata <= {2'b00, CNT_W'(0), 1'b0, 1'b1, CNT_W'(count)};
                end else if (full) begin
                  m_tdata <= {2'b00, CNT_W'(0), 1'b1, 1'b0, CNT_W'(count)};
                end else begin
                  count   <= count + CW'(1);
                  m_tdata <= {2'b00, CNT_W'(0), 1'b0, 1'b0, CNT_W'(count + CW'(1))};
                end
              end
              CMD_TICK: begin
                state   <= ST_COMPACT;
                expired <= '0;
              end
              CMD_CLEAR: begin
                count    <= '0;
                m_tvalid <= 1'b1;
                m_tdata  <= '0;
              end
              default: begin
                m_tvalid <= 1'b1;
                m_tdata  <= {2'b00, CNT_W'(0), 1'b0, 1'b0, CNT_W'(count)};
              end
            endcase
          end
        end
        ST_COMPACT: begin
          if (any_kill) begin
            count   <= count - CW'(1);
            expired <= expired + CW'(1);
          end else begin
            state    <= ST_IDLE;
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, CNT_W'(expired), 1'b0, 1'b0, CNT_W'(count)};
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_CAP))
    else $error("entry count above capacity");

  a_no_result_while_compacting: assert property (@(posedge clk) disable iff (rst)
    state == ST_COMPACT |-> !m_tvalid)
    else $error("result shown during compaction");

  a_compact_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMPACT) && any_kill |=> count == $past(count) - CW'(1))
    else $error("compaction did not remove one entry");

  a_single_cycle_ops: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd != CMD_TICK) |=> m_tvalid && (state == ST_IDLE))
    else $error("one-cycle command gave no result");

endmodule

// ----- verif/aging_event_table_core_tb.sv -----
`timescale 1ns / 1ps

module aging_event_table_core_tb;
  import aet_pkg::*;

  localparam int TABLE_CAP = CAP_DEFAULT;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 2 * TABLE_CAP + 16;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]        pad;
    logic [LIFE_W-1:0] time_step;
    logic [KIND_W-1:0] kind;
    logic [LIFE_W-1:0] lifetime;
    logic [RAD_W-1:0]  radius;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_x;
  } event_word_t;

  typedef struct packed {
    logic [1:0]       pad;
    logic [CNT_W-1:0] expired_count;
    logic             oldest_evicted;
    logic             push_rejected;
    logic [CNT_W-1:0] entry_count;
  } status_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // pos_x[15:0], pos_y[31:16], radius[43:32], lifetime[59:44], kind[61:60],
  // time_step[77:62], zero[79:78]
  logic [S_TDATA_W-1:0] s_tdata = '0;
  // command[1:0]
  logic [CMD_W-1:0]     s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // entry_count[5:0], push_rejected[6], oldest_evicted[7], expired_count[13:8],
  // zero[15:14]
  logic [M_TDATA_W-1:0] m_tdata;

  entry_t      event_table[$];
  status_t     status_q[$];
  int          errors = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          n_pushes = 0;
  int          n_ticks = 0;
  int          n_evictions = 0;
  int          n_rejected = 0;
  int          n_expired = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  logic        m_hold = 1'b0;
  int unsigned cycles = 0;

  aging_event_table_core #(.TABLE_CAP(TABLE_CAP)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               status_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= !m_hold && ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic status_t apply_command(cmd_t cmd, event_word_t w);
    status_t     st;
    entry_t      e;
    entry_t      kept[$];
    int unsigned sum;
    int          expired;
    st = '0;
    expired = 0;
    case (cmd)
      CMD_PUSH: begin
        n_pushes++;
        e.pos_x = w.pos_x;
        e.pos_y = w.pos_y;
        e.radius = w.radius;
        e.life = w.lifetime;
        e.age = '0;
        e.kind = w.kind;
        if (w.radius == '0 || w.lifetime == '0) begin
          st.push_rejected = 1'b1;
          n_rejected++;
        end else begin
          if (event_table.size() >= TABLE_CAP) begin
            void'(event_table.pop_front());
            st.oldest_evicted = 1'b1;
            n_evictions++;
          end
          event_table = {event_table, e};
        end
      end
      CMD_TICK: begin
        n_ticks++;
        foreach (event_table[i]) begin
          e = event_table[i];
          sum = e.age + w.time_step;
          e.age = (sum > AGE_MAX) ? AGE_MAX : sum[LIFE_W-1:0];
          if (e.age >= e.life) expired++;
          else kept = {kept, e};
        end
        event_table = kept;
        n_expired += expired;
      end
      CMD_CLEAR: begin
        event_table.delete();
      end
      default: begin
      end
    endcase
    st.expired_count = expired[CNT_W-1:0];
    st.entry_count = CNT_W'(event_table.size());
    return st;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH result %0d: %s is %0d, should be %0d", results_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : result_check
    status_t got;
    status_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = status_t'(m_tdata);
      if (status_q.size() == 0) begin
        report_mismatch("unexpected result, entry_count", got.entry_count, -1);
      end else begin
        want = status_q.pop_front();
        if (got.entry_count !== want.entry_count)
          report_mismatch("entry_count", got.entry_count, want.entry_count);
        if (got.push_rejected !== want.push_rejected)
          report_mismatch("push_rejected", got.push_rejected, want.push_rejected);
        if (got.oldest_evicted !== want.oldest_evicted)
          report_mismatch("oldest_evicted", got.oldest_evicted, want.oldest_evicted);
        if (got.expired_count !== want.expired_count)
          report_mismatch("expired_count", got.expired_count, want.expired_count);
      end
      results_seen++;
    end
  end

  task automatic send_item(input cmd_t cmd, input event_word_t w);
    status_t st;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    s_tuser <= cmd;
    do @(posedge clk); while (!s_tready);
    st = apply_command(cmd, w);
    status_q = {status_q, st};
    items_sent++;
  endtask

  function automatic event_word_t random_word();
    event_word_t w;
    w = '0;
    w.pos_x = POS_W'($urandom);
    w.pos_y = POS_W'($urandom);
    w.radius = ($urandom_range(99) < 4) ? '0 : RAD_W'($urandom_range(1, 4095));
    case ($urandom_range(9))
      0, 1, 2, 3: w.lifetime = LIFE_W'($urandom_range(1, 255));
      4, 5, 6, 7: w.lifetime = LIFE_W'($urandom_range(256, 16383));
      default:    w.lifetime = LIFE_W'($urandom);
    endcase
    if ($urandom_range(99) < 4) w.lifetime = '0;
    w.kind = KIND_W'($urandom);
    case ($urandom_range(99)) inside
      [0:59]:  w.time_step = LIFE_W'($urandom_range(0, 16));
      [60:84]: w.time_step = LIFE_W'($urandom_range(0, 256));
      [85:96]: w.time_step = LIFE_W'($urandom_range(0, 4095));
      default: w.time_step = LIFE_W'($urandom);
    endcase
    return w;
  endfunction

  function automatic event_word_t event_fields(input int x, input int y, input int rad,
                                               input int life, input int kind);
    event_word_t w;
    w = random_word();
    w.pos_x = POS_W'(x);
    w.pos_y = POS_W'(y);
    w.radius = RAD_W'(rad);
    w.lifetime = LIFE_W'(life);
    w.kind = KIND_W'(kind);
    return w;
  endfunction

  function automatic event_word_t tick_of(input int step);
    event_word_t w;
    w = random_word();
    w.time_step = LIFE_W'(step);
    return w;
  endfunction

  task automatic send_random_item();
    event_word_t w;
    int unsigned pick;
    cmd_t        cmd;
    w = random_word();
    pick = $urandom_range(99);
    if (pick < 60) cmd = CMD_PUSH;
    else if (pick < 96) cmd = CMD_TICK;
    else if (pick < 97) cmd = CMD_CLEAR;
    else cmd = CMD_NOP;
    send_item(cmd, w);
  endtask

  task automatic test_directed();
    send_item(CMD_TICK, tick_of(0));
    send_item(CMD_NOP, random_word());
    send_item(CMD_PUSH, event_fields(5, 6, 0, 100, 1));
    send_item(CMD_PUSH, event_fields(7, 8, 10, 0, 2));
    send_item(CMD_PUSH, event_fields(9, 10, 0, 0, 3));
    send_item(CMD_PUSH, event_fields(-32768, 32767, 4095, 65535, 3));
    send_item(CMD_PUSH, event_fields(32767, -32768, 1, 1, 0));
    send_item(CMD_PUSH, event_fields(-1, 0, 2048, 100, 1));
    send_item(CMD_PUSH, event_fields(0, -1, 100, 300, 2));
    send_item(CMD_TICK, tick_of(0));
    send_item(CMD_TICK, tick_of(1));
    send_item(CMD_TICK, tick_of(150));
    send_item(CMD_PUSH, event_fields(1, 1, 1, 65535, 0));
    send_item(CMD_TICK, tick_of(40000));
    send_item(CMD_TICK, tick_of(40000));
    send_item(CMD_PUSH, event_fields(2, 2, 3, 5, 1));
    send_item(CMD_PUSH, event_fields(3, 3, 4, 65535, 2));
    send_item(CMD_TICK, tick_of(65535));
    send_item(CMD_PUSH, event_fields(4, 4, 5, 50, 3));
    send_item(CMD_PUSH, event_fields(5, 5, 6, 60, 0));
    send_item(CMD_NOP, random_word());
    send_item(CMD_CLEAR, random_word());
    send_item(CMD_TICK, tick_of(10));
    send_item(CMD_CLEAR, random_word());
  endtask

  task automatic test_eviction();
    event_word_t w;
    for (int pass = 0; pass < 2; pass++) begin
      for (int i = 0; i < TABLE_CAP + 10; i++) begin
        w = random_word();
        w.radius = RAD_W'($urandom_range(1, 4095));
        w.lifetime = (pass == 0) ? LIFE_W'($urandom_range(1, 65535)) :
                                   LIFE_W'($urandom_range(1, 2000));
        send_item(CMD_PUSH, w);
      end
      send_item(CMD_PUSH, event_fields(0, 0, 0, 10, 0));
      send_item(CMD_TICK, tick_of((pass == 0) ? 65535 : 1000));
    end
    send_item(CMD_CLEAR, random_word());
  endtask

  task automatic test_random_traffic();
    int idle_pct[4] = '{0, 59, 0, 20};
    int stall_pct[4] = '{0, 0, 59, 20};
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = idle_pct[ph];
      sink_stall_pct = stall_pct[ph];
      repeat (340) send_random_item();
    end
    src_idle_pct = 0;
    sink_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        m_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_hold <= 1'b0;
      end
    join_none
    repeat (60) send_random_item();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_eviction();
    test_random_traffic();
    test_backpressure();
    s_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items: %0d pushes (%0d rejected, %0d evictions), %0d ticks",
             items_sent, n_pushes, n_rejected, n_evictions, n_ticks);
    $display("expiring %0d entries, with clears, unused commands and stalls on both sides.",
             n_expired);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
